// File: rtl/m61_pkg.sv
// Shared types, constants and helpers for the Mersenne-61 field arithmetic unit.
`default_nettype none
package m61_pkg;

    // Field modulus p = 2^61 - 1 and element width.
    localparam int FIELD_W = 61;
    localparam logic [FIELD_W-1:0] FIELD_P = {FIELD_W{1'b1}};

    // Operand split for the partial-product multiplier.
    localparam int LO_W = 31;
    localparam int HI_W = FIELD_W - LO_W;
    localparam int PROD_W = 2 * FIELD_W;

    // Exponent p-2 is scanned from bit 59 down; bit 60 seeds the accumulator.
    localparam int EXP_CNT_W = 6;
    localparam logic [EXP_CNT_W-1:0] EXP_TOP = 6'd59;
    localparam logic [EXP_CNT_W-1:0] EXP_ZERO_BIT = 6'd1;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef logic [FIELD_W-1:0] elem_t;

    typedef enum logic [2:0] {
        OP_REDUCE = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4
    } op_t;

    // One classified request held in the queue.
    typedef struct packed {
        op_t   op;
        elem_t a;
        elem_t b;
    } item_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_SQ_ISSUE,
        ST_MUL_ISSUE,
        ST_WAIT,
        ST_FIN_ISSUE
    } seq_state_t;

    // Bring a value below 2p into the range 0..p-1.
    function automatic elem_t cond_sub_p(logic [FIELD_W:0] s);
        logic [FIELD_W:0] t;
        t = s;
        if (s >= {1'b0, FIELD_P})
        begin
            t = s - {1'b0, FIELD_P};
        end
        return t[FIELD_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/m61_req_if.sv
// Request channel: operation code and two operands with valid/ready handshake.
`default_nettype none
interface m61_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [63:0] operand_a;
    logic [60:0] operand_b;

    modport source (output valid, output req_type, output operand_a, output operand_b,
                    input ready);
    modport sink (input valid, input req_type, input operand_a, input operand_b,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/m61_rsp_if.sv
// Response channel: field result and divide-by-zero flag with valid/ready handshake.
`default_nettype none
interface m61_rsp_if;
    logic        valid;
    logic        ready;
    logic [60:0] field_result;
    logic        div_by_zero;

    modport source (output valid, output field_result, output div_by_zero, input ready);
    modport sink (input valid, input field_result, input div_by_zero, output ready);
endinterface
`default_nettype wire

// File: rtl/m61_front.sv
// Front end: accepts request beats, reduces the operands and classifies the operation.
`default_nettype none
module m61_front
    import m61_pkg::*;
(
    m61_req_if.sink req,
    input  logic    full,
    output logic    push,
    output item_t   item
);

    logic [FIELD_W:0] a_fold;

    // Accept whenever the queue has room.
    assign req.ready = !full;
    assign push      = req.valid && !full;

    // Fold the top three bits of operand a back onto the low 61 bits.
    assign a_fold = {1'b0, req.operand_a[FIELD_W-1:0]}
                  + {{(FIELD_W-2){1'b0}}, req.operand_a[63:FIELD_W]};

    always_comb
    begin
        item.a = cond_sub_p(a_fold);
        // The all-ones pattern equals p and reduces to zero.
        item.b = (req.operand_b == FIELD_P) ? '0 : req.operand_b;
        case (req.req_type)
            OP_ADD:  item.op = OP_ADD;
            OP_SUB:  item.op = OP_SUB;
            OP_MUL:  item.op = OP_MUL;
            OP_DIV:  item.op = OP_DIV;
            default: item.op = OP_REDUCE;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/m61_fifo.sv
// Short queue of classified requests between the front end and the execution back end.
`default_nettype none
module m61_fifo
    import m61_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and count bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// File: rtl/m61_back.sv
// Back end: add, subtract and reduce, a three-stage modular multiplier and an inversion sequencer.
`default_nettype none
module m61_back
    import m61_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  item_t     head_item,
    output logic      pop,
    m61_rsp_if.source rsp
);

    // Sequencer state.
    seq_state_t           state_reg, state_next;
    logic [EXP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 kind_sq_reg, kind_sq_next;
    elem_t                acc_reg, acc_next;
    elem_t                bdiv_reg, bdiv_next;
    elem_t                adiv_reg, adiv_next;

    // Issue slot.
    logic  iss_valid, iss_int, iss_mul, iss_flag;
    elem_t iss_res, iss_x, iss_y;

    // Stage 1: partial products.
    logic                   s1_valid_reg, s1_int_reg, s1_mul_reg, s1_flag_reg;
    elem_t                  s1_res_reg;
    logic [2*LO_W-1:0]      p00_reg;
    logic [LO_W+HI_W-1:0]   p01_reg, p10_reg;
    logic [2*HI_W-1:0]      p11_reg;

    // Stage 2: full product.
    logic                   s2_valid_reg, s2_int_reg, s2_mul_reg, s2_flag_reg;
    elem_t                  s2_res_reg;
    logic [PROD_W-1:0]      s2_full_reg;
    logic [PROD_W-1:0]      full_sum;

    // Output register.
    logic  out_valid_reg;
    elem_t out_res_reg;
    logic  out_flag_reg;

    logic             adv;
    logic             ret;
    logic             head_div;
    logic [FIELD_W:0] fold1;
    logic [FIELD_W:0] fold2;
    elem_t            mul_val;
    logic [FIELD_W:0] add_sum;
    logic [FIELD_W:0] sub_wrap;

    assign adv       = !out_valid_reg || rsp.ready;
    assign rsp.valid        = out_valid_reg;
    assign rsp.field_result = out_res_reg;
    assign rsp.div_by_zero  = out_flag_reg;

    assign head_div = head_valid && (head_item.op == OP_DIV) && (head_item.b != '0);

    // Final fold of the product: 2^61 is one modulo p.
    assign fold1   = {1'b0, s2_full_reg[FIELD_W-1:0]} + {1'b0, s2_full_reg[PROD_W-1:FIELD_W]};
    assign fold2   = {1'b0, fold1[FIELD_W-1:0]} + {{FIELD_W{1'b0}}, fold1[FIELD_W]};
    assign mul_val = cond_sub_p(fold2);
    assign ret     = adv && s2_valid_reg && s2_int_reg;

    assign add_sum  = {1'b0, head_item.a} + {1'b0, head_item.b};
    assign sub_wrap = {1'b0, head_item.a} + {1'b0, FIELD_P} - {1'b0, head_item.b};

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (head_div)
                begin
                    state_next = ST_SQ_ISSUE;
                end
            end
            ST_SQ_ISSUE, ST_MUL_ISSUE:
            begin
                if (adv)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (ret)
                begin
                    if (kind_sq_reg && (cnt_reg != EXP_ZERO_BIT))
                    begin
                        state_next = ST_MUL_ISSUE;
                    end
                    else if (cnt_reg == '0)
                    begin
                        state_next = ST_FIN_ISSUE;
                    end
                    else
                    begin
                        state_next = ST_SQ_ISSUE;
                    end
                end
            end
            ST_FIN_ISSUE:
            begin
                if (adv)
                begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    // Issue slot and queue pop, by state.
    always_comb
    begin
        iss_valid = 1'b0;
        iss_int   = 1'b0;
        iss_mul   = 1'b0;
        iss_flag  = 1'b0;
        iss_res   = head_item.a;
        iss_x     = head_item.a;
        iss_y     = head_item.b;
        pop       = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                if (head_valid && !head_div)
                begin
                    iss_valid = 1'b1;
                    pop       = adv;
                    case (head_item.op)
                        OP_ADD:  iss_res = cond_sub_p(add_sum);
                        OP_SUB:
                        begin
                            if (head_item.a >= head_item.b)
                            begin
                                iss_res = head_item.a - head_item.b;
                            end
                            else
                            begin
                                iss_res = sub_wrap[FIELD_W-1:0];
                            end
                        end
                        OP_MUL:  iss_mul = 1'b1;
                        OP_DIV:
                        begin
                            iss_res  = '0;
                            iss_flag = 1'b1;
                        end
                        default: iss_res = head_item.a;
                    endcase
                end
            end
            ST_SQ_ISSUE:
            begin
                iss_valid = 1'b1;
                iss_int   = 1'b1;
                iss_mul   = 1'b1;
                iss_x     = acc_reg;
                iss_y     = acc_reg;
            end
            ST_MUL_ISSUE:
            begin
                iss_valid = 1'b1;
                iss_int   = 1'b1;
                iss_mul   = 1'b1;
                iss_x     = acc_reg;
                iss_y     = bdiv_reg;
            end
            ST_FIN_ISSUE:
            begin
                iss_valid = 1'b1;
                iss_mul   = 1'b1;
                iss_x     = adiv_reg;
                iss_y     = acc_reg;
                pop       = adv;
            end
            default: iss_valid = 1'b0;
        endcase
    end

    // Sequencer data: accumulator, saved operands and exponent bit index.
    always_comb
    begin
        cnt_next     = cnt_reg;
        kind_sq_next = kind_sq_reg;
        acc_next     = acc_reg;
        bdiv_next    = bdiv_reg;
        adiv_next    = adiv_reg;
        if ((state_reg == ST_RUN) && head_div)
        begin
            acc_next  = head_item.b;
            bdiv_next = head_item.b;
            adiv_next = head_item.a;
            cnt_next  = EXP_TOP;
        end
        if ((state_reg == ST_SQ_ISSUE) && adv)
        begin
            kind_sq_next = 1'b1;
        end
        if ((state_reg == ST_MUL_ISSUE) && adv)
        begin
            kind_sq_next = 1'b0;
        end
        if ((state_reg == ST_WAIT) && ret)
        begin
            acc_next = mul_val;
            if (!(kind_sq_reg && (cnt_reg != EXP_ZERO_BIT)) && (cnt_reg != '0))
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        kind_sq_reg <= kind_sq_next;
        acc_reg     <= acc_next;
        bdiv_reg    <= bdiv_next;
        adiv_reg    <= adiv_next;
    end

    // Sum of the partial products into the full 122-bit product.
    assign full_sum = {{(PROD_W-2*LO_W){1'b0}}, p00_reg}
                    + ({{(PROD_W-LO_W-HI_W){1'b0}}, p01_reg} << LO_W)
                    + ({{(PROD_W-LO_W-HI_W){1'b0}}, p10_reg} << LO_W)
                    + ({{(PROD_W-2*HI_W){1'b0}}, p11_reg} << (2*LO_W));

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= iss_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && !s2_int_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_int_reg  <= iss_int;
            s1_mul_reg  <= iss_mul;
            s1_flag_reg <= iss_flag;
            s1_res_reg  <= iss_res;
            p00_reg     <= iss_x[LO_W-1:0] * iss_y[LO_W-1:0];
            p01_reg     <= iss_x[LO_W-1:0] * iss_y[FIELD_W-1:LO_W];
            p10_reg     <= iss_x[FIELD_W-1:LO_W] * iss_y[LO_W-1:0];
            p11_reg     <= iss_x[FIELD_W-1:LO_W] * iss_y[FIELD_W-1:LO_W];

            s2_int_reg  <= s1_int_reg;
            s2_mul_reg  <= s1_mul_reg;
            s2_flag_reg <= s1_flag_reg;
            s2_res_reg  <= s1_res_reg;
            s2_full_reg <= full_sum;

            out_res_reg  <= s2_mul_reg ? mul_val : s2_res_reg;
            out_flag_reg <= s2_flag_reg;
        end
    end

endmodule
`default_nettype wire

// File: rtl/mersenne61_field_alu_top.sv
// Top level of the arithmetic unit over the prime field modulo 2^61-1.
//
// Requests arrive on the req channel (req_type, operand_a, operand_b) and
// one response per request leaves on the rsp channel (field_result,
// div_by_zero), in request order. A beat moves when valid and ready are high.
// The front end reduces the operands and writes a queue; the back end
// drains it into a multiplier pipeline (partial products, full product) and
// an output register. Reduce, add, subtract, multiply and divide by zero
// take one beat per cycle while the receiver keeps ready high. A request
// passes the queue, the multiplier stages and the output register before
// its response is presented. A divide by a nonzero element raises the
// divisor to p-2 by square-and-multiply through the shared multiplier: 119
// dependent products plus the final product, during which later requests
// wait in the queue.
// When the receiver holds ready low, the pipeline holds and the queue
// fills; req.ready falls once the queue is full. Reset empties the queue,
// the pipeline and the output register.
`default_nettype none
module mersenne61_field_alu_top
    import m61_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    m61_req_if.sink   req,
    m61_rsp_if.source rsp
);

    logic  push;
    logic  full;
    logic  pop;
    logic  head_valid;
    item_t push_item;
    item_t head_item;

    m61_front u_front (
        .req  (req),
        .full (full),
        .push (push),
        .item (push_item)
    );

    m61_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    m61_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule
`default_nettype wire

// File: dv/m61_alu_checker.sv
// Scoreboard for the Mersenne-61 field unit: predicts each response and compares it.
module m61_alu_checker
    import m61_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    m61_req_if        req,
    m61_rsp_if        rsp,
    output int        fail_count,
    output int        pending
);

    typedef struct {
        elem_t value;
        logic  dz;
    } field_answer_t;

    field_answer_t answers_q[$];

    // Reduce any 64-bit value into 0..p-1.
    function automatic elem_t mod_p64(logic [63:0] x);
        logic [63:0] r;
        r = x % {3'd0, FIELD_P};
        return r[FIELD_W-1:0];
    endfunction

    // Product of two elements modulo p, done on the full wide product.
    function automatic elem_t mul_mod_p(elem_t x, elem_t y);
        logic [127:0] prod;
        prod = {67'd0, x} * {67'd0, y};
        prod = prod % {67'd0, FIELD_P};
        return prod[FIELD_W-1:0];
    endfunction

    // Inverse by Fermat: y^(p-2), scanning the exponent from the low bit.
    function automatic elem_t inv_mod_p(elem_t y);
        elem_t acc;
        elem_t base;
        elem_t e;
        acc = 1;
        base = y;
        e = FIELD_P - 2;
        for (int i = 0; i < FIELD_W; i++)
        begin
            if (e[i])
            begin
                acc = mul_mod_p(acc, base);
            end
            base = mul_mod_p(base, base);
        end
        return acc;
    endfunction

    // Expected response for one request beat.
    function automatic field_answer_t field_op_result(logic [2:0] code, logic [63:0] ra,
                                                      logic [60:0] rb);
        field_answer_t ans;
        elem_t a;
        elem_t b;
        logic [FIELD_W:0] s;
        a = mod_p64(ra);
        b = (rb == FIELD_P) ? '0 : rb;
        ans.value = a;
        ans.dz = 1'b0;
        case (code)
            OP_ADD:
            begin
                s = {1'b0, a} + {1'b0, b};
                if (s >= {1'b0, FIELD_P})
                begin
                    s = s - {1'b0, FIELD_P};
                end
                ans.value = s[FIELD_W-1:0];
            end
            OP_SUB:
            begin
                s = (a >= b) ? {1'b0, a - b} : ({1'b0, a} + {1'b0, FIELD_P} - {1'b0, b});
                ans.value = s[FIELD_W-1:0];
            end
            OP_MUL:
            begin
                ans.value = mul_mod_p(a, b);
            end
            OP_DIV:
            begin
                if (b == '0)
                begin
                    ans.value = '0;
                    ans.dz = 1'b1;
                end
                else
                begin
                    ans.value = mul_mod_p(a, inv_mod_p(b));
                end
            end
            default:
            begin
                ans.value = a;
            end
        endcase
        return ans;
    endfunction

    assign pending = answers_q.size();

    // Record each accepted request and check each accepted response.
    always @(posedge clk or negedge rst_n)
    begin
        field_answer_t want;
        if (!rst_n)
        begin
            answers_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                answers_q.push_back(field_op_result(req.req_type, req.operand_a,
                                                    req.operand_b));
            end
            if (rsp.valid && rsp.ready)
            begin
                if (answers_q.size() == 0)
                begin
                    $display("%0t: unexpected response beat: result %h flag %b", $time,
                             rsp.field_result, rsp.div_by_zero);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = answers_q.pop_front();
                    if (rsp.field_result !== want.value)
                    begin
                        $display("%0t: field_result expected %h actual %h", $time,
                                 want.value, rsp.field_result);
                        fail_count <= fail_count + 1;
                    end
                    else if (rsp.div_by_zero !== want.dz)
                    begin
                        $display("%0t: div_by_zero expected %b actual %b", $time,
                                 want.dz, rsp.div_by_zero);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: dv/tb_mersenne61_field_alu_top.sv
// Testbench top: clock, reset, request stimulus, response stalls and the verdict.
module tb_mersenne61_field_alu_top;
    import m61_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int PHASE_ITEMS = 420;
    localparam int CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   src_idle_pct;
    int   rcv_stall_pct;
    longint unsigned cycles;

    m61_req_if req ();
    m61_rsp_if rsp ();

    mersenne61_field_alu_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    m61_alu_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the total run length.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver stalls at the rate of the current phase.
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp.ready <= rst_n && ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Present one request beat and hold it until it is taken.
    task automatic send_req(logic [2:0] code, logic [63:0] a, logic [60:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            req.req_type <= 3'($urandom);
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.req_type <= code;
        req.operand_a <= a;
        req.operand_b <= b;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Mix of small values, values around p and full-range values.
    function automatic logic [63:0] pick_a();
        case ($urandom_range(4))
            0: return 64'($urandom_range(3));
            1: return {3'd0, FIELD_P} - 64'($urandom_range(3));
            2: return {3'd0, FIELD_P} + 64'($urandom_range(8));
            3: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [60:0] pick_b();
        case ($urandom_range(4))
            0: return 61'($urandom_range(3));
            1: return FIELD_P - 61'($urandom_range(4));
            default: return 61'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 5)
        begin
            return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        else if (r < 12)
        begin
            return OP_DIV;
        end
        return 3'($urandom_range(OP_REDUCE, OP_MUL));
    endfunction

    task automatic wait_drained();
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.req_type = OP_REDUCE;
        req.operand_a = '0;
        req.operand_b = '0;
        src_idle_pct = 0;
        rcv_stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: extremes, every operation, unreduced operands, spare codes.
        send_req(OP_REDUCE, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        send_req(OP_REDUCE, {3'd0, FIELD_P}, FIELD_P);
        send_req(OP_REDUCE, 64'd0, '0);
        send_req(OP_ADD, {3'd0, FIELD_P} - 1, FIELD_P - 1);
        send_req(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, FIELD_P);
        send_req(OP_SUB, 64'd0, FIELD_P - 1);
        send_req(OP_SUB, {3'd0, FIELD_P}, FIELD_P);
        send_req(OP_SUB, 64'd5, 61'd5);
        send_req(OP_MUL, {3'd0, FIELD_P} - 1, FIELD_P - 1);
        send_req(OP_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 61'h1555_5555_5555_5555);
        send_req(OP_MUL, 64'd0, FIELD_P - 1);
        send_req(OP_DIV, 64'd7, 61'd0);
        send_req(OP_DIV, 64'd7, FIELD_P);
        send_req(OP_DIV, 64'hFFFF_FFFF_FFFF_FFFF, 61'd1);
        send_req(OP_DIV, 64'd1, FIELD_P - 1);
        send_req(OP_DIV, 64'd3, 61'd2);
        send_req(OP_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF, 61'd0);
        send_req(3'd6, {3'd0, FIELD_P} + 5, FIELD_P);
        send_req(OP_SPARE_HI, 64'h0123_4567_89AB_CDEF, 61'd9);
        req.valid <= 1'b0;
        @(posedge clk);

        // Hold off until every directed response has arrived.
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct = (ph == 1) ? 74 : (ph == 3) ? 13 : 0;
            rcv_stall_pct = (ph == 2) ? 74 : (ph == 3) ? 13 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_req(pick_op(), pick_a(), pick_b());
            end
        end
        req.valid <= 1'b0;

        wait_drained();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
